// ----- src/rsae_pkg.sv -----
// ----------------------------------------------------------------------------
// rsae_pkg
// Types, constants and elaboration-time tables for the GF(32) address encoder.
// ----------------------------------------------------------------------------
package rsae_pkg;

    // one GF(32) symbol
    typedef logic [4:0] t_sym;

    // check-symbol columns: entry b is the 20-bit check word of a lone account bit b
    typedef logic [63:0][19:0] t_col_tab;

    localparam int unsigned DATA_COUNT = 13;
    localparam int unsigned SYM_COUNT  = 17;
    localparam int unsigned PRE_LEN    = 6;
    localparam int unsigned BODY_LEN   = 20;

    // character positions within one address run
    localparam logic [4:0] FIRST_POS = 5'd0;
    localparam logic [4:0] BODY_POS  = 5'd6;
    localparam logic [4:0] LAST_POS  = 5'd25;

    // slot code that marks a dash in the body layout
    localparam logic [4:0] DASH_SLOT = 5'd31;

    localparam logic [7:0] DASH_CHAR = "-";

    // generator taps
    localparam logic [4:0] TAP0 = 5'd17;
    localparam logic [4:0] TAP1 = 5'd9;
    localparam logic [4:0] TAP2 = 5'd6;
    localparam logic [4:0] TAP3 = 5'd30;

    // field polynomial x^5 + x^2 + 1 without the top term
    localparam logic [4:0] FIELD_POLY = 5'h05;

    localparam logic [7:0] LETTERS [32] = '{
        "2", "3", "4", "5", "6", "7", "8", "9",
        "A", "B", "C", "D", "E", "F", "G", "H",
        "J", "K", "L", "M", "N", "P", "Q", "R",
        "S", "T", "U", "V", "W", "X", "Y", "Z"
    };

    localparam logic [7:0] PREFIX [PRE_LEN] = '{"B", "U", "R", "S", "T", "-"};

    // codeword index sent at each symbol place
    localparam logic [4:0] SEND_ORDER [SYM_COUNT] = '{
        5'd3, 5'd2, 5'd1, 5'd0, 5'd7, 5'd6, 5'd5, 5'd4, 5'd13,
        5'd14, 5'd15, 5'd16, 5'd12, 5'd8, 5'd9, 5'd10, 5'd11
    };

    // body layout: symbol place per character, dash after the 4th, 8th and 12th
    localparam logic [4:0] BODY_SLOT [BODY_LEN] = '{
        5'd0,  5'd1,  5'd2,  5'd3,  DASH_SLOT,
        5'd4,  5'd5,  5'd6,  5'd7,  DASH_SLOT,
        5'd8,  5'd9,  5'd10, 5'd11, DASH_SLOT,
        5'd12, 5'd13, 5'd14, 5'd15, 5'd16
    };

    // GF(32) product
    function automatic t_sym gf_mul(input t_sym x, input t_sym y);
        t_sym acc;
        t_sym a;
        acc = '0;
        a   = x;
        for (int k = 0; k < 5; k++) begin
            if (y[k]) begin
                acc = acc ^ a;
            end
            a = a[4] ? ({a[3:0], 1'b0} ^ FIELD_POLY) : {a[3:0], 1'b0};
        end
        return acc;
    endfunction

    // shift-register encoder, used at elaboration only to build the columns
    function automatic logic [19:0] check_word(input logic [63:0] acct);
        t_sym c0, c1, c2, c3, d, fb;
        c0 = '0;
        c1 = '0;
        c2 = '0;
        c3 = '0;
        for (int i = DATA_COUNT - 1; i >= 0; i--) begin
            d  = (i == DATA_COUNT - 1) ? {1'b0, acct[63:60]} : t_sym'(acct >> (5 * i));
            fb = d ^ c3;
            c3 = c2 ^ gf_mul(TAP3, fb);
            c2 = c1 ^ gf_mul(TAP2, fb);
            c1 = c0 ^ gf_mul(TAP1, fb);
            c0 = gf_mul(TAP0, fb);
        end
        return {c3, c2, c1, c0};
    endfunction

    function automatic t_col_tab build_cols();
        t_col_tab cols;
        for (int b = 0; b < 64; b++) begin
            cols[b] = check_word(64'd1 << b);
        end
        return cols;
    endfunction

    // the code is linear, so the check word is the XOR of these columns
    localparam t_col_tab CHECK_COL = build_cols();

endpackage

// ----- src/rsae_in_if.sv -----
// ----------------------------------------------------------------------------
// rsae_in_if
// Input channel: one account number and its prefix flag per transfer.
// ----------------------------------------------------------------------------
interface rsae_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] account;
    logic        with_prefix;

    modport source (output valid, output account, output with_prefix, input ready);
    modport sink   (input valid, input account, input with_prefix, output ready);
endinterface

// ----- src/rsae_out_if.sv -----
// ----------------------------------------------------------------------------
// rsae_out_if
// Output channel: one address character per transfer, last on the final one.
// ----------------------------------------------------------------------------
interface rsae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- src/rs_gf32_account_address_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// rs_gf32_account_address_encoder_unit
// Reed-Solomon (17,13) GF(32) account address encoder with character output.
// ----------------------------------------------------------------------------
// Each account transfer becomes a run of 20 ASCII characters, or 26 when
// with_prefix is set, sent one per cycle while the output is ready; last marks
// the final character, and the output serializer sets the rate. The account is
// held in an input register, its four check symbols come from a combinational
// XOR network over the account bits, and the permuted codeword is loaded into
// the serializer register. The next account is taken into the input register
// while the current run is still going out, and moves on the cycle the final
// character transfers, so runs follow gap-free. An account passes the input
// register, then the serializer register, before its first character appears.
module rs_gf32_account_address_encoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsae_in_if.sink    i_in,
    rsae_out_if.source o_out
);
    import rsae_pkg::*;

    // input register
    logic        r_a_valid;
    logic [63:0] r_a_account;
    logic        r_a_prefix;

    // serializer register
    logic        r_b_valid;
    logic [4:0]  r_b_pos;
    t_sym        r_b_send [SYM_COUNT];

    logic        done_b;
    logic        load_b;
    logic [19:0] check;
    t_sym        cw [SYM_COUNT];
    logic [4:0]  body_idx;
    logic [4:0]  slot;

    // handshake
    assign done_b     = r_b_valid && o_out.ready && (r_b_pos == LAST_POS);
    assign load_b     = r_a_valid && (!r_b_valid || done_b);
    assign i_in.ready = !r_a_valid || load_b;

    // capture the incoming account
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_a_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_a_account <= i_in.account;
            r_a_prefix  <= i_in.with_prefix;
        end
    end

    // XOR the check columns of all set account bits
    always_comb begin
        check = '0;
        for (int b = 0; b < 64; b++) begin
            if (r_a_account[b]) begin
                check = check ^ CHECK_COL[b];
            end
        end
    end

    // assemble the codeword: data symbols, then the four check symbols
    always_comb begin
        for (int i = 0; i < DATA_COUNT - 1; i++) begin
            cw[i] = r_a_account[5*i +: 5];
        end
        cw[DATA_COUNT - 1] = {1'b0, r_a_account[63:60]};
        for (int i = 0; i < 4; i++) begin
            cw[DATA_COUNT + i] = check[5*i +: 5];
        end
    end

    // load the permuted codeword and step through the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_pos   <= FIRST_POS;
        end else if (load_b) begin
            r_b_valid <= 1'b1;
            r_b_pos   <= r_a_prefix ? FIRST_POS : BODY_POS;
        end else if (done_b) begin
            r_b_valid <= 1'b0;
        end else if (r_b_valid && o_out.ready) begin
            r_b_pos   <= r_b_pos + 5'd1;
        end
        if (load_b) begin
            for (int i = 0; i < SYM_COUNT; i++) begin
                r_b_send[i] <= cw[SEND_ORDER[i]];
            end
        end
    end

    // pick the character for the current position
    assign body_idx = r_b_pos - BODY_POS;
    assign slot     = BODY_SLOT[body_idx];

    always_comb begin
        if (r_b_pos < BODY_POS) begin
            o_out.character = PREFIX[r_b_pos[2:0]];
        end else if (slot == DASH_SLOT) begin
            o_out.character = DASH_CHAR;
        end else begin
            o_out.character = LETTERS[r_b_send[slot]];
        end
    end

    assign o_out.valid = r_b_valid;
    assign o_out.last  = (r_b_pos == LAST_POS);

endmodule
